>>> hdl/cffdp_pkg.sv
// Package for the CFF Top DICT parser: payload structs, event format,
// byte classes, operator and status codes. No dependencies.
package cffdp_pkg;

  localparam int MAX_OPERANDS = 48;
  localparam int OPND_CNT_W   = $clog2(MAX_OPERANDS + 1);

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
  localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  // configuration register indexes
  localparam logic [7:0] CFG_TABLE_OFFSET = 8'd0;
  localparam logic [7:0] CFG_TABLE_LENGTH = 8'd1;

  // DICT byte classes
  localparam logic [7:0] BYTE_ESCAPE    = 8'd12;
  localparam logic [7:0] BYTE_INT16     = 8'd28;
  localparam logic [7:0] BYTE_INT32     = 8'd29;
  localparam logic [7:0] BYTE_REAL      = 8'd30;
  localparam logic [7:0] BYTE_RSVD_LO   = 8'd31;
  localparam logic [7:0] BYTE_RSVD_HI   = 8'd255;
  localparam logic [7:0] BYTE_SMALL_LO  = 8'd32;
  localparam logic [7:0] BYTE_SMALL_HI  = 8'd246;
  localparam logic [7:0] BYTE_POS_FIRST = 8'd247;
  localparam logic [7:0] BYTE_POS_LAST  = 8'd250;
  localparam logic [7:0] BYTE_NEG_FIRST = 8'd251;
  localparam logic [7:0] BYTE_NEG_LAST  = 8'd254;
  localparam logic [31:0] SMALL_BIAS    = 32'd139;
  localparam logic [31:0] TWO_BYTE_BIAS = 32'd108;
  localparam logic [3:0]  REAL_END      = 4'hF;
  localparam logic [3:0]  ESC_PREFIX    = 4'hC;

  // operators
  localparam logic [11:0] OP_CHARSTRINGS = 12'd17;
  localparam logic [11:0] OP_PRIVATE     = 12'd18;

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_NUMBER   = 3'd1;
  localparam logic [2:0] ST_STACK_OVF    = 3'd2;
  localparam logic [2:0] ST_TRUNC_ESC    = 3'd3;
  localparam logic [2:0] ST_BAD_CS       = 3'd4;
  localparam logic [2:0] ST_BAD_PRIV     = 3'd5;
  localparam logic [2:0] ST_MISSING_CS   = 3'd6;
  localparam logic [2:0] ST_PRIV_OUTSIDE = 3'd7;

  typedef struct packed {
    logic [7:0] dict_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] charstrings_offset;
    logic        private_present;
    logic [30:0] private_size;
    logic [31:0] private_offset;
  } out_item_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_PUSH = 2'd1,
    EV_OP   = 2'd2,
    EV_ERR  = 2'd3
  } ev_kind_e;

  // one decoded token: operand value, operator code or error code
  typedef struct packed {
    ev_kind_e    kind;
    logic [31:0] data;
    logic        last;
  } ev_t;

  typedef struct packed {
    logic [31:0] table_offset;
    logic [31:0] table_length;
  } cfg_t;

endpackage

>>> hdl/cffdp_front.sv
// Byte decoder: turns DICT bytes into operand, operator and error events.
// Depends on cffdp_pkg.
module cffdp_front
  import cffdp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t in_item_i,
  output logic     ev_valid_o,
  output ev_t      ev_o
);

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_TWO  = 6'b000010,
    MODE_INT  = 6'b000100,
    MODE_REAL = 6'b001000,
    MODE_ESC  = 6'b010000,
    MODE_SKIP = 6'b100000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  lead_q, lead_d;
  ev_t         ev;

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  lead_off;
    logic [31:0] mag;
    logic [31:0] acc_n;
    logic [2:0]  left_n;
    b        = in_item_i.dict_byte;
    mode_d   = mode_q;
    left_d   = left_q;
    acc_d    = acc_q;
    lead_d   = lead_q;
    ev.kind  = EV_NONE;
    ev.data  = '0;
    ev.last  = in_item_i.is_last;
    lead_off = (lead_q <= BYTE_POS_LAST) ? (lead_q - BYTE_POS_FIRST)
                                         : (lead_q - BYTE_NEG_FIRST);
    mag      = {22'd0, lead_off[1:0], b} + TWO_BYTE_BIAS;
    acc_n    = {acc_q[23:0], b};
    left_n   = left_q - 3'd1;

    unique case (mode_q)
      MODE_IDLE: begin
        unique case (b) inside
          [BYTE_SMALL_LO:BYTE_SMALL_HI]: begin
            ev.kind = EV_PUSH;
            ev.data = {24'd0, b} - SMALL_BIAS;
          end
          [BYTE_POS_FIRST:BYTE_NEG_LAST]: begin
            lead_d = b;
            left_d = 3'd1;
            mode_d = MODE_TWO;
          end
          BYTE_INT16, BYTE_INT32: begin
            lead_d = b;
            left_d = (b == BYTE_INT16) ? 3'd2 : 3'd4;
            acc_d  = '0;
            mode_d = MODE_INT;
          end
          BYTE_REAL:   mode_d = MODE_REAL;
          BYTE_RSVD_LO, BYTE_RSVD_HI: begin
            ev.kind = EV_ERR;
            ev.data = {29'd0, ST_BAD_NUMBER};
            mode_d  = MODE_SKIP;
          end
          BYTE_ESCAPE: mode_d = MODE_ESC;
          default: begin
            ev.kind = EV_OP;
            ev.data = {24'd0, b};
          end
        endcase
      end
      MODE_TWO: begin
        left_d  = '0;
        ev.kind = EV_PUSH;
        ev.data = (lead_q <= BYTE_POS_LAST) ? mag : (32'd0 - mag);
        mode_d  = MODE_IDLE;
      end
      MODE_INT: begin
        acc_d  = acc_n;
        left_d = left_n;
        if (left_n == 3'd0) begin
          ev.kind = EV_PUSH;
          ev.data = (lead_q == BYTE_INT16) ? {{16{acc_n[15]}}, acc_n[15:0]} : acc_n;
          mode_d  = MODE_IDLE;
        end
      end
      MODE_REAL: begin
        if (b[7:4] == REAL_END || b[3:0] == REAL_END) begin
          ev.kind = EV_PUSH;
          mode_d  = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        ev.kind = EV_OP;
        ev.data = {20'd0, ESC_PREFIX, b};
        mode_d  = MODE_IDLE;
      end
      MODE_SKIP: ;
      default:   mode_d = MODE_IDLE;
    endcase

    // a number or escape still open at the end of the dict
    if (in_item_i.is_last) begin
      if (mode_d != MODE_IDLE && mode_d != MODE_SKIP) begin
        ev.kind = EV_ERR;
        ev.data = {29'd0, (mode_d == MODE_ESC) ? ST_TRUNC_ESC : ST_BAD_NUMBER};
      end
      mode_d = MODE_IDLE;
      left_d = '0;
      acc_d  = '0;
      lead_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      left_q <= '0;
      acc_q  <= '0;
      lead_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      left_q <= left_d;
      acc_q  <= acc_d;
      lead_q <= lead_d;
    end
  end

  assign ev_valid_o = accept_i && (ev.kind != EV_NONE || ev.last);
  assign ev_o       = ev;

endmodule

>>> hdl/cffdp_evq.sv
// Short event queue between decoder and executor.
// Depends on cffdp_pkg.
module cffdp_evq
  import cffdp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  ev_t  wr_ev_i,
  output logic full_o,
  output logic valid_o,
  output ev_t  rd_ev_o,
  input  logic rd_i
);

  ev_t                  mem_q [EVQ_DEPTH];
  logic [EVQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [EVQ_CNT_W-1:0] cnt_q;
  logic                 do_wr, do_rd;

  assign full_o  = (cnt_q == EVQ_CNT_W'(EVQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rd_ev_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_ev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + EVQ_PTR_W'(1);
      if (do_rd) rd_ptr_q <= rd_ptr_q + EVQ_PTR_W'(1);
      if (do_wr && !do_rd)      cnt_q <= cnt_q + EVQ_CNT_W'(1);
      else if (!do_wr && do_rd) cnt_q <= cnt_q - EVQ_CNT_W'(1);
    end
  end

endmodule

>>> hdl/cffdp_back.sv
// Executor: operand stack count, operator captures, end-of-dict checks,
// result register. Depends on cffdp_pkg.
module cffdp_back
  import cffdp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      ev_valid_i,
  input  ev_t       ev_i,
  output logic      ev_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  // parse state
  logic [OPND_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]           first_q, first_d, second_q, second_d;
  logic                  have_q, have_d;
  logic [30:0]           cs_q, cs_d, psize_q, psize_d, poff_q, poff_d;
  logic [2:0]            err_q, err_d;

  // snapshot at the end of a dict
  logic        fin_valid_q;
  logic [2:0]  fin_err_q;
  logic        fin_have_q;
  logic [30:0] fin_cs_q, fin_psize_q, fin_poff_q;

  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      fin_move, take;

  assign fin_move = fin_valid_q && (!out_valid_q || pop_i);
  assign take     = ev_valid_i && (!ev_i.last || !fin_valid_q || fin_move);
  assign ev_pop_o = take;

  always_comb begin
    cnt_d    = cnt_q;
    first_d  = first_q;
    second_d = second_q;
    have_d   = have_q;
    cs_d     = cs_q;
    psize_d  = psize_q;
    poff_d   = poff_q;
    err_d    = err_q;
    if (err_q == ST_OK) begin
      unique case (ev_i.kind)
        EV_PUSH: begin
          if (cnt_q >= OPND_CNT_W'(MAX_OPERANDS)) begin
            err_d = ST_STACK_OVF;
          end else begin
            if (cnt_q == OPND_CNT_W'(0)) first_d  = ev_i.data;
            if (cnt_q == OPND_CNT_W'(1)) second_d = ev_i.data;
            cnt_d = cnt_q + OPND_CNT_W'(1);
          end
        end
        EV_OP: begin
          cnt_d = '0;
          if (ev_i.data[11:0] == OP_CHARSTRINGS) begin
            if (cnt_q != OPND_CNT_W'(1) || first_q[31]) begin
              err_d = ST_BAD_CS;
            end else begin
              cs_d   = first_q[30:0];
              have_d = 1'b1;
            end
          end else if (ev_i.data[11:0] == OP_PRIVATE) begin
            if (cnt_q != OPND_CNT_W'(2) || first_q[31] || second_q[31]) begin
              err_d = ST_BAD_PRIV;
            end else begin
              psize_d = first_q[30:0];
              poff_d  = second_q[30:0];
            end
          end
        end
        EV_ERR:  err_d = ev_i.data[2:0];
        EV_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      have_q   <= 1'b0;
      cs_q     <= '0;
      psize_q  <= '0;
      poff_q   <= '0;
      err_q    <= ST_OK;
    end else if (take) begin
      if (ev_i.last) begin
        cnt_q    <= '0;
        first_q  <= '0;
        second_q <= '0;
        have_q   <= 1'b0;
        cs_q     <= '0;
        psize_q  <= '0;
        poff_q   <= '0;
        err_q    <= ST_OK;
      end else begin
        cnt_q    <= cnt_d;
        first_q  <= first_d;
        second_q <= second_d;
        have_q   <= have_d;
        cs_q     <= cs_d;
        psize_q  <= psize_d;
        poff_q   <= poff_d;
        err_q    <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ev_i.last) begin
      fin_err_q   <= err_d;
      fin_have_q  <= have_d;
      fin_cs_q    <= cs_d;
      fin_psize_q <= psize_d;
      fin_poff_q  <= poff_d;
    end
  end

  // range checks against the table length
  always_comb begin
    logic [31:0] room;
    logic [2:0]  st;
    room = cfg_i.table_length - {1'b0, fin_poff_q};
    st   = fin_err_q;
    if (st == ST_OK && (!fin_have_q || {1'b0, fin_cs_q} >= cfg_i.table_length)) begin
      st = ST_MISSING_CS;
    end
    if (st == ST_OK && fin_psize_q != '0 &&
        ({1'b0, fin_poff_q} > cfg_i.table_length || {1'b0, fin_psize_q} > room)) begin
      st = ST_PRIV_OUTSIDE;
    end
    out_d        = '0;
    out_d.status = st;
    if (st == ST_OK) begin
      out_d.charstrings_offset = fin_cs_q;
      if (fin_psize_q != '0) begin
        out_d.private_present = 1'b1;
        out_d.private_size    = fin_psize_q;
        out_d.private_offset  = cfg_i.table_offset + {1'b0, fin_poff_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && ev_i.last) fin_valid_q <= 1'b1;
      else if (fin_move)     fin_valid_q <= 1'b0;
      if (fin_move)              out_valid_q <= 1'b1;
      else if (pop_i)            out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_move) out_q <= out_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

>>> hdl/cff_top_dict_parser_unit.sv
// CFF Top DICT parser, top level: configuration registers, decoder,
// event queue and executor. Depends on cffdp_pkg and the cffdp_* modules.
//
// Feed the Top DICT one byte per request on the input queue, marking the final
// byte with is_last; one result request appears on the output queue per dict.
// Bytes are taken at one per cycle: the decoder handles every byte in the
// cycle it is accepted, and full rises only when the four-entry event queue
// between decoder and executor is backed up, which happens once the result
// register and the end-of-dict snapshot are both waiting on pop. A result
// becomes visible after its last byte passes the queue write at the accepting
// edge, the end snapshot and the result register. Both result stages let
// the next dict stream in while a result waits. table_offset and table_length
// are written through the cfg channel, which is always ready; write them only
// while no dict is in flight. Status 0 means ok; any other status zeroes the
// remaining fields.
module cff_top_dict_parser_unit
  import cffdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item_i,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  logic accept;
  logic ev_wr, ev_full, ev_valid, ev_pop;
  ev_t  ev_wr_data, ev_rd_data;

  assign cfg_ready_o = 1'b1;

  // writes to indexes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TABLE_OFFSET) cfg_q.table_offset <= cfg_data_i;
      if (cfg_index_i == CFG_TABLE_LENGTH) cfg_q.table_length <= cfg_data_i;
    end
  end

  assign full   = ev_full;
  assign accept = push && !ev_full;

  cffdp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .ev_valid_o (ev_wr),
    .ev_o       (ev_wr_data)
  );

  cffdp_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ev_wr),
    .wr_ev_i (ev_wr_data),
    .full_o  (ev_full),
    .valid_o (ev_valid),
    .rd_ev_o (ev_rd_data),
    .rd_i    (ev_pop)
  );

  cffdp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .ev_valid_i (ev_valid),
    .ev_i       (ev_rd_data),
    .ev_pop_o   (ev_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

>>> hdl/cffdp_checker.sv
// Port-level checks for the CFF Top DICT parser, bound to the top level.
// Depends on cffdp_pkg.
module cffdp_checker
  import cffdp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // nothing can be waiting right after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> empty)
    else $error("result shown right after reset");

  a_error_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status != ST_OK) |->
      (out_item_o.charstrings_offset == '0 && !out_item_o.private_present &&
       out_item_o.private_size == '0 && out_item_o.private_offset == '0))
    else $error("error result carries nonzero fields");

  a_private_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.private_present) |->
      (out_item_o.status == ST_OK && out_item_o.private_size != '0))
    else $error("private flagged with bad status or zero size");

  a_no_private_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.private_present) |->
      (out_item_o.private_size == '0 && out_item_o.private_offset == '0))
    else $error("private fields set without private flag");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or dropped");

endmodule

bind cff_top_dict_parser_unit cffdp_checker u_cffdp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

>>> tb/cff_top_dict_parser_unit_tb.sv
// Testbench for cff_top_dict_parser_unit: directed stimulus table, then random
// Top DICTs checked against a parse predictor inside this file.
// Depends on cffdp_pkg and the DUT sources under hdl/.
`timescale 1ns / 100ps

module cff_top_dict_parser_unit_tb;
  import cffdp_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT signals, inputs all driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_item_t    in_item   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  always #4 clk = ~clk;

  cff_top_dict_parser_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Parse predictor: a private copy of the decoder state and the registers.
  // ---------------------------------------------------------------------------
  typedef enum logic [2:0] {
    PM_IDLE, PM_TWO, PM_INT, PM_REAL, PM_ESC, PM_SKIP
  } parse_mode_e;

  parse_mode_e pm_mode;
  logic [2:0]  pm_left;
  logic [31:0] pm_acc;
  logic [7:0]  pm_lead;
  logic [5:0]  pm_count;
  logic [31:0] pm_first;
  logic [31:0] pm_second;
  logic        pm_have_cs;
  logic [30:0] pm_cs;
  logic [30:0] pm_psize;
  logic [30:0] pm_poff;
  logic [2:0]  pm_err;

  logic [31:0] reg_table_offset = '0;
  logic [31:0] reg_table_length = '0;

  out_item_t   dict_results_due[$];  // results predicted, not yet popped
  int          fail_cnt   = 0;
  int          live_bytes = 0;       // byte requests sent so far
  bit          no_gaps    = 1'b0;    // burst stretch: no idling on either side

  function automatic void clear_dict_state();
    pm_mode    = PM_IDLE;
    pm_left    = '0;
    pm_acc     = '0;
    pm_lead    = '0;
    pm_count   = '0;
    pm_first   = '0;
    pm_second  = '0;
    pm_have_cs = 1'b0;
    pm_cs      = '0;
    pm_psize   = '0;
    pm_poff    = '0;
    pm_err     = ST_OK;
  endfunction

  function automatic void stack_push(logic [31:0] v);
    pm_mode = PM_IDLE;
    if (pm_count >= MAX_OPERANDS) begin
      pm_err = ST_STACK_OVF;
      return;
    end
    // only the two bottom operands matter to operators 17 and 18
    if (pm_count == 0) pm_first = v;
    else if (pm_count == 1) pm_second = v;
    pm_count++;
  endfunction

  function automatic void run_dict_op(logic [11:0] op);
    pm_mode = PM_IDLE;
    if (op == OP_CHARSTRINGS) begin
      if (pm_count != 1 || pm_first[31]) begin
        pm_err = ST_BAD_CS;
        return;
      end
      pm_cs      = pm_first[30:0];
      pm_have_cs = 1'b1;
    end else if (op == OP_PRIVATE) begin
      if (pm_count != 2 || pm_first[31] || pm_second[31]) begin
        pm_err = ST_BAD_PRIV;
        return;
      end
      pm_psize = pm_first[30:0];
      pm_poff  = pm_second[30:0];
    end
    pm_count = '0;
  endfunction

  function automatic void decode_dict_byte(logic [7:0] b);
    logic [31:0] mag;
    logic [31:0] v;
    case (pm_mode)
      PM_IDLE: begin
        if (b >= BYTE_SMALL_LO && b <= BYTE_SMALL_HI) begin
          stack_push(32'(b) - SMALL_BIAS);
        end else if (b >= BYTE_POS_FIRST && b <= BYTE_NEG_LAST) begin
          pm_lead = b;
          pm_left = 3'd1;
          pm_mode = PM_TWO;
        end else if (b == BYTE_INT16 || b == BYTE_INT32) begin
          pm_lead = b;
          pm_left = (b == BYTE_INT16) ? 3'd2 : 3'd4;
          pm_acc  = '0;
          pm_mode = PM_INT;
        end else if (b == BYTE_REAL) begin
          pm_mode = PM_REAL;
        end else if (b == BYTE_RSVD_LO || b == BYTE_RSVD_HI) begin
          pm_err = ST_BAD_NUMBER;
        end else if (b == BYTE_ESCAPE) begin
          pm_mode = PM_ESC;
        end else begin
          run_dict_op({4'h0, b});
        end
      end
      PM_TWO: begin
        pm_left = '0;
        mag = (32'(pm_lead) - ((pm_lead <= BYTE_POS_LAST) ? 32'(BYTE_POS_FIRST)
                                                           : 32'(BYTE_NEG_FIRST)))
              * 32'd256 + 32'(b) + TWO_BYTE_BIAS;
        stack_push((pm_lead <= BYTE_POS_LAST) ? mag : 32'd0 - mag);
      end
      PM_INT: begin
        pm_acc  = {pm_acc[23:0], b};
        pm_left = pm_left - 3'd1;
        if (pm_left == 0) begin
          v = pm_acc;
          if (pm_lead == BYTE_INT16) v = {{16{pm_acc[15]}}, pm_acc[15:0]};
          stack_push(v);
        end
      end
      PM_REAL: begin
        // a real ends at the first 0xF nibble and stands for zero
        if (b[7:4] == REAL_END || b[3:0] == REAL_END) stack_push(32'd0);
      end
      PM_ESC: begin
        run_dict_op({ESC_PREFIX, b});
      end
      default: ;
    endcase
  endfunction

  // Advances the predictor by one request; returns 1 with the dict result
  // when the request carries the last byte.
  function automatic bit parse_dict_byte(in_item_t it, output out_item_t res);
    logic [2:0] st;
    res = '0;
    if (pm_mode != PM_SKIP && pm_err == ST_OK) decode_dict_byte(it.dict_byte);
    if (it.is_last && pm_err == ST_OK && pm_mode != PM_IDLE)
      pm_err = (pm_mode == PM_ESC) ? ST_TRUNC_ESC : ST_BAD_NUMBER;
    if (pm_err != ST_OK) pm_mode = PM_SKIP;
    if (!it.is_last) return 1'b0;

    st = pm_err;
    if (st == ST_OK && (!pm_have_cs || {1'b0, pm_cs} >= reg_table_length))
      st = ST_MISSING_CS;
    if (st == ST_OK && pm_psize != 0 &&
        ({1'b0, pm_poff} > reg_table_length ||
         {1'b0, pm_psize} > reg_table_length - {1'b0, pm_poff}))
      st = ST_PRIV_OUTSIDE;

    res.status = st;
    if (st == ST_OK) begin
      res.charstrings_offset = pm_cs;
      if (pm_psize != 0) begin
        res.private_present = 1'b1;
        res.private_size    = pm_psize;
        res.private_offset  = reg_table_offset + {1'b0, pm_poff};
      end
    end
    clear_dict_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly back to back, some short gaps, a few long ones
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, and the checker
  // ---------------------------------------------------------------------------
  int pop_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop      <= 1'b0;
      pop_wait <= 0;
    end else if (pop && !empty) begin
      // a request was taken at this edge: pick the stall before the next one
      pop_wait <= idle_len();
      pop      <= 1'b0;
    end else if (pop_wait != 0) begin
      pop_wait <= pop_wait - 1;
      pop      <= 1'b0;
    end else begin
      pop      <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (dict_results_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: result with nothing expected: st=%0d cs=%0h", $realtime,
                   out_item.status, out_item.charstrings_offset);
      end else begin
        want = dict_results_due.pop_front();
        if (want.status !== out_item.status ||
            want.charstrings_offset !== out_item.charstrings_offset ||
            want.private_present !== out_item.private_present ||
            want.private_size !== out_item.private_size ||
            want.private_offset !== out_item.private_offset) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: mismatch exp st=%0d cs=%0h pp=%0b ps=%0h po=%0h",
                     $realtime, want.status, want.charstrings_offset,
                     want.private_present, want.private_size, want.private_offset,
                     "\n          got st=%0d cs=%0h pp=%0b ps=%0h po=%0h",
                     out_item.status, out_item.charstrings_offset,
                     out_item.private_present, out_item.private_size,
                     out_item.private_offset);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Sends one byte request. A directed row may carry a result typed in by
  // hand; it then replaces the predicted one (the predictor still advances).
  task automatic send_byte(input in_item_t it, input bit typed, input out_item_t typed_res);
    int        gap;
    out_item_t res;
    gap = idle_len();
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    live_bytes++;
    if (parse_dict_byte(it, res))
      dict_results_due.insert(dict_results_due.size(), typed ? typed_res : res);
  endtask

  // Holds the sender until every predicted result has been popped, then lets
  // the pipeline settle.
  task automatic drain_results();
    push <= 1'b0;
    while (dict_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TABLE_OFFSET) reg_table_offset = data;
    else if (idx == CFG_TABLE_LENGTH) reg_table_length = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random dict generation
  // ---------------------------------------------------------------------------
  logic [7:0] dict_bytes[$];

  function automatic void add_dict_byte(logic [7:0] b);
    dict_bytes.insert(dict_bytes.size(), b);
  endfunction

  // largest value an offset operand may take before the sign bit trips
  function automatic logic [31:0] operand_cap();
    return (reg_table_length > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : reg_table_length;
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'($urandom_range(0, 214)) - 32'd107;
    if (r == 4) return 32'd108 + 32'($urandom_range(0, 1023));
    if (r == 5) return 32'd0 - (32'd108 + 32'($urandom_range(0, 1023)));
    if (r < 8) return 32'($urandom_range(0, 65535)) - 32'd32768;
    return $urandom();
  endfunction

  // Encodes a value in one of the forms that can hold it, picked at random.
  function automatic void put_number(logic [31:0] v);
    int s;
    int t;
    int fmt;
    s   = signed'(v);
    fmt = $urandom_range(0, 3);
    if (fmt >= 2 && s >= -107 && s <= 107) begin
      add_dict_byte(8'(s + 139));
    end else if (fmt >= 2 && s >= 108 && s <= 1131) begin
      t = s - 108;
      add_dict_byte(8'(247 + t / 256));
      add_dict_byte(8'(t % 256));
    end else if (fmt >= 2 && s <= -108 && s >= -1131) begin
      t = -s - 108;
      add_dict_byte(8'(251 + t / 256));
      add_dict_byte(8'(t % 256));
    end else if (fmt >= 1 && s >= -32768 && s <= 32767) begin
      add_dict_byte(BYTE_INT16);
      add_dict_byte(v[15:8]);
      add_dict_byte(v[7:0]);
    end else begin
      add_dict_byte(BYTE_INT32);
      add_dict_byte(v[31:24]);
      add_dict_byte(v[23:16]);
      add_dict_byte(v[15:8]);
      add_dict_byte(v[7:0]);
    end
  endfunction

  // Real number: a few nibble pairs without 0xF, then a byte ending it on
  // either nibble.
  function automatic void put_real();
    add_dict_byte(BYTE_REAL);
    repeat ($urandom_range(0, 3))
      add_dict_byte({4'($urandom_range(0, 14)), 4'($urandom_range(0, 14))});
    if ($urandom_range(0, 1)) add_dict_byte({REAL_END, 4'($urandom())});
    else add_dict_byte({4'($urandom()), REAL_END});
  endfunction

  // Some operands, then an operator the parser only uses to clear the stack.
  function automatic void put_plain_entry();
    logic [7:0] b;
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 4) == 0) put_real();
      else put_number(rand_value());
    end
    if ($urandom_range(0, 3) == 0) begin
      add_dict_byte(BYTE_ESCAPE);
      add_dict_byte(8'($urandom()));
    end else begin
      do b = 8'($urandom_range(0, 21));
      while (b == BYTE_ESCAPE || b == 8'(OP_CHARSTRINGS) || b == 8'(OP_PRIVATE));
      add_dict_byte(b);
    end
  endfunction

  function automatic void put_charstrings();
    logic [31:0] cap;
    logic [31:0] v;
    int          r;
    cap = operand_cap();
    r   = $urandom_range(0, 19);
    if (r == 0) begin
      // wrong operand count: none or two
      repeat ($urandom_range(0, 1) * 2) put_number(rand_value());
    end else begin
      if (r == 1) v = $urandom();
      else if (r == 2) v = cap + 32'($urandom_range(0, 2));
      else if (r == 3 && cap != 0) v = cap - 32'd1;
      else v = (cap == 0) ? 32'd0 : 32'($urandom_range(0, cap - 32'd1));
      put_number(v);
    end
    add_dict_byte(8'(OP_CHARSTRINGS));
  endfunction

  function automatic void put_private();
    logic [31:0] cap;
    logic [31:0] off;
    logic [31:0] size;
    int          r;
    cap  = operand_cap();
    r    = $urandom_range(0, 11);
    off  = $urandom_range(0, cap);
    size = $urandom_range(0, cap - off);
    case (r)
      0: size = '0;
      1: size = cap - off;                            // exact fit at the end
      2: size = $urandom() & 32'h7FFF_FFFF;
      3: off  = cap + 32'($urandom_range(1, 4));      // past the table
      5: size = $urandom();                           // may carry the sign bit
      default: ;
    endcase
    put_number(size);
    if (r != 4) put_number(off);                      // r == 4: one operand only
    add_dict_byte(8'(OP_PRIVATE));
  endfunction

  // Builds one dict: mostly well formed with random content, the rest cut
  // short, overflowing the operand stack, or plain noise.
  function automatic void build_dict();
    int kind;
    int n_plain;
    int cs_at;
    int pv_at;
    bit has_cs;
    bit has_pv;
    int keep;
    dict_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      n_plain = $urandom_range(0, 3);
      cs_at   = $urandom_range(0, n_plain);
      pv_at   = $urandom_range(0, n_plain);
      has_cs  = ($urandom_range(0, 9) != 0);
      has_pv  = ($urandom_range(0, 9) < 6);
      for (int i = 0; i <= n_plain; i++) begin
        if (has_cs && i == cs_at) put_charstrings();
        if (has_pv && i == pv_at) put_private();
        if (i < n_plain) put_plain_entry();
      end
      if (dict_bytes.size() == 0) put_plain_entry();
      if (kind == 7) begin
        keep = $urandom_range(1, dict_bytes.size());
        while (dict_bytes.size() > keep) void'(dict_bytes.pop_back());
      end
    end else if (kind == 8) begin
      // around the stack limit: one short of it up to two past it
      repeat (MAX_OPERANDS - 1 + $urandom_range(0, 3))
        add_dict_byte(8'($urandom_range(32, 246)));
      put_charstrings();
    end else begin
      repeat ($urandom_range(1, 16)) add_dict_byte(8'($urandom()));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t directed_rows[$];

  // typed rows here all expect zeros beside the status
  function automatic dir_row_t dir_row(logic [7:0] b, bit last, bit typed = 1'b0,
                                       logic [2:0] st = ST_OK);
    dir_row_t r;
    r.item.dict_byte = b;
    r.item.is_last   = last;
    r.typed          = typed;
    r.want           = '0;
    r.want.status    = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int          budget;
    in_item_t    it;
    logic [31:0] off_v;
    logic [31:0] len_v;

    clear_dict_state();
    directed_rows = '{
      // operand 0 then CharStrings: ok, every field zero
      dir_row(8'd139, 0), dir_row(8'(OP_CHARSTRINGS), 1, 1, ST_OK),
      // escape as the last byte
      dir_row(BYTE_ESCAPE, 1, 1, ST_TRUNC_ESC),
      // reserved lead bytes; the byte after the error is ignored
      dir_row(BYTE_RSVD_LO, 0), dir_row(8'd139, 1, 1, ST_BAD_NUMBER),
      dir_row(BYTE_RSVD_HI, 1, 1, ST_BAD_NUMBER),
      // real, escaped operator, then an int16 cut off by the end
      dir_row(BYTE_REAL, 0), dir_row(8'h1F, 0), dir_row(BYTE_ESCAPE, 0),
      dir_row(8'h05, 0), dir_row(BYTE_INT16, 0), dir_row(8'h80, 1, 1, ST_BAD_NUMBER),
      // no CharStrings operator
      dir_row(8'd139, 1, 1, ST_MISSING_CS),
      // CharStrings with an empty stack
      dir_row(8'(OP_CHARSTRINGS), 1, 1, ST_BAD_CS),
      // int32 CharStrings 256, Private size 16 at 108: predicted
      dir_row(BYTE_INT32, 0), dir_row(8'h00, 0), dir_row(8'h00, 0), dir_row(8'h01, 0),
      dir_row(8'h00, 0), dir_row(8'(OP_CHARSTRINGS), 0),
      dir_row(BYTE_INT16, 0), dir_row(8'h00, 0), dir_row(8'h10, 0),
      dir_row(BYTE_POS_FIRST, 0), dir_row(8'h00, 0), dir_row(8'(OP_PRIVATE), 1)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_TABLE_OFFSET, 32'h0000_0100);
    write_reg(CFG_TABLE_LENGTH, 32'd1000);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // random phases, each under its own register setting
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin off_v = '0;                len_v = '0; end
        1: begin off_v = 32'hFFFF_FFFF;     len_v = 32'hFFFF_FFFF; end
        2: begin off_v = $urandom();        len_v = $urandom_range(1, 3000); end
        3: begin off_v = $urandom();        len_v = $urandom(); end
        4: begin off_v = $urandom();        len_v = 32'h7FFF_FFFF; end
        default: begin off_v = $urandom(); len_v = $urandom_range(100, 200000); end
      endcase
      write_reg(CFG_TABLE_OFFSET, off_v);
      write_reg(CFG_TABLE_LENGTH, len_v);

      budget = live_bytes + 235;
      while (live_bytes < budget) begin
        build_dict();
        no_gaps = ($urandom_range(0, 4) == 0);
        // now and then the sender holds until the result side is empty
        if ($urandom_range(0, 11) == 0) drain_results();
        foreach (dict_bytes[i]) begin
          it.dict_byte = dict_bytes[i];
          it.is_last   = (i == dict_bytes.size() - 1);
          send_byte(it, 1'b0, '0);
        end
      end
      no_gaps = 1'b0;
      drain_results();
    end

    // drain_results already waited for the queue; give stray results a chance
    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && dict_results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> cff_top_dict_parser_unit.f
hdl/cffdp_pkg.sv
hdl/cffdp_front.sv
hdl/cffdp_evq.sv
hdl/cffdp_back.sv
hdl/cff_top_dict_parser_unit.sv
hdl/cffdp_checker.sv
tb/cff_top_dict_parser_unit_tb.sv
